// File: design/aps_pkg.sv
// Shared types, constants and the interval helper for the announcement period scheduler.
// Used by aps_div, aps_dp, aps_ctrl and the top level.
package aps_pkg;

  localparam logic [1:0] MODE_POLL   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [31:0] MIN_PERIOD  = 32'd10;
  localparam logic [31:0] MAX_PERIOD  = 32'd31536000;  // one year in seconds
  localparam logic [31:0] EARLY_COUNT = 32'd5;
  localparam logic [15:0] POLL_RESET  = 16'd60;

  // ceil(2^35/10); product >> 35 is p/10 and product >> 34 is p/5, exact for 32-bit p
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

  localparam int unsigned DIV_STEPS = 31;  // bits of the jitter value

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] last;
    logic [31:0] count;
  } slot_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_COMMIT,
    ST_ADD_IV,
    ST_ADD_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;       // capture the input transaction
    logic dispatch;   // preset result, remove, start of a scan
    logic mul_add;    // multiplier takes the added period
    logic issue;      // read the next slot into the scan pipe
    logic div_start;  // load the remainder unit
    logic add_write;  // store the added slot
    logic commit;     // commit a due slot, set the poll timeout
    logic out_load;   // move the result to the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       issue_done;
    logic       scan_end;
    logic       div_busy;
    logic       out_busy;
  } stat_t;

  function automatic logic [31:0] interval(input logic [31:0] count,
                                           input logic [31:0] period,
                                           input logic [63:0] prod);
    logic [31:0] iv;
    if (count == 32'd0) begin
      iv = 32'(prod[63:35]);
    end else if (count < EARLY_COUNT) begin
      iv = 32'(prod[63:34]);
    end else begin
      iv = period;
    end
    if (iv == 32'd0) begin
      iv = 32'd1;
    end
    return iv;
  endfunction

endpackage

// File: design/aps_div.sv
// Bit-serial remainder unit: 31-bit dividend modulo a 32-bit divisor, one bit per cycle.
// Depends on aps_pkg.
module aps_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] rem
);

  logic [30:0] quo_sh;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem, quo_sh[30]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(aps_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= dividend;
      dvs    <= divisor;
      rem    <= 32'd0;
    end else if (busy) begin
      quo_sh <= {quo_sh[29:0], 1'b0};
      // remainder stays below the divisor, so the trial fits 33 bits
      if (trial >= {1'b0, dvs}) begin
        rem <= 32'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[31:0];
      end
    end
  end

endmodule

// File: design/aps_dp.sv
// Datapath: slot memory, valid bits, scan pipeline with shared multiplier,
// remainder unit, config register and output register. Depends on aps_pkg, aps_div.
module aps_dp #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  aps_pkg::cmd_t       cmd,
  output aps_pkg::stat_t      stat,
  input  logic [1:0]          in_mode,
  input  logic [130:0]        in_data,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [36:0]         out_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  // captured transaction
  logic [1:0]  mode;
  logic [2:0]  slot;
  logic [31:0] now_s;
  logic [31:0] add_period;
  logic [30:0] rand_value;
  logic [31:0] current_timeout;
  logic        can_send;

  logic [15:0] poll_timeout;

  logic [NUM_SLOTS-1:0]  slot_valid;
  aps_pkg::slot_word_t   mem [NUM_SLOTS];
  aps_pkg::slot_word_t   rd_word;
  aps_pkg::slot_word_t   wr_word;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_en;

  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;

  // scan pipeline
  logic [CNT_W-1:0] scan_cnt;
  logic [IDX_W-1:0] scan_addr;
  logic             a_vld, a_sv;
  logic [IDX_W-1:0] a_idx;
  logic             b_vld, b_sched;
  logic [IDX_W-1:0] b_idx;
  logic [31:0]      b_period, b_last, b_count;
  logic [63:0]      prod;
  logic [31:0]      mul_a;
  logic             c_vld, c_sched;
  logic [IDX_W-1:0] c_idx;
  logic [31:0]      c_period, c_count, c_next;
  logic             due;
  logic [31:0]      diff;
  logic             eval_done;

  // found slot and result
  logic [IDX_W-1:0] f_idx;
  logic [31:0]      f_period, f_count;
  logic             res_found, res_ok;
  logic [2:0]       res_slot;
  logic [31:0]      res_tmo;

  logic [31:0] div_rem;
  logic        div_busy;

  assign slot_ok  = 32'(slot) < 32'(NUM_SLOTS);
  assign slot_idx = IDX_W'(slot);
  assign scan_addr = scan_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode            <= in_mode;
      slot            <= in_data[2:0];
      now_s           <= in_data[34:3];
      add_period      <= in_data[66:35];
      rand_value      <= in_data[97:67];
      current_timeout <= in_data[129:98];
      can_send        <= in_data[130];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_timeout <= aps_pkg::POLL_RESET;
    end else if (cfg_valid) begin
      poll_timeout <= cfg_data;
    end
  end

  // slot memory: one write port, registered read at the scan address
  always_comb begin
    if (cmd.add_write) begin
      wr_addr = slot_idx;
      wr_word = '{period: add_period, last: now_s - div_rem, count: 32'd0};
      wr_en   = slot_ok;
    end else begin
      wr_addr = f_idx;
      wr_word = '{period: f_period, last: now_s, count: f_count + 32'd1};
      wr_en   = cmd.commit && res_found && can_send;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word <= mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.dispatch && mode == aps_pkg::MODE_REMOVE && slot_ok) begin
      slot_valid[slot_idx] <= 1'b0;
    end else if (cmd.add_write && slot_ok) begin
      slot_valid[slot_idx] <= 1'b1;
    end
  end

  // scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      eval_done <= 1'b0;
    end else if (cmd.dispatch) begin
      scan_cnt  <= '0;
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      eval_done <= 1'b0;
    end else begin
      a_vld <= cmd.issue && !stat.issue_done;
      if (cmd.issue && !stat.issue_done) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      b_vld <= a_vld;
      c_vld <= b_vld;
      if (c_vld && c_idx == IDX_W'(NUM_SLOTS - 1)) begin
        eval_done <= 1'b1;
      end
    end
  end

  assign mul_a = cmd.mul_add ? add_period : rd_word.period;

  always_ff @(posedge clk) begin
    a_idx <= scan_addr;
    a_sv  <= slot_valid[scan_addr];

    prod     <= 64'(mul_a) * 64'(aps_pkg::RECIP_10);
    b_idx    <= a_idx;
    b_period <= rd_word.period;
    b_last   <= rd_word.last;
    b_count  <= rd_word.count;
    b_sched  <= a_sv && rd_word.period >= aps_pkg::MIN_PERIOD
                     && rd_word.period <= aps_pkg::MAX_PERIOD;

    c_idx    <= b_idx;
    c_sched  <= b_sched;
    c_period <= b_period;
    c_count  <= b_count;
    c_next   <= b_last + aps_pkg::interval(b_count, b_period, prod);
  end

  // no wrap correction on the due test
  assign due  = c_next <= now_s;
  assign diff = c_next - now_s;

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      res_found <= 1'b0;
      res_slot  <= 3'd0;
      res_tmo   <= 32'd0;
      res_ok    <= 1'b0;
      unique case (mode)
        aps_pkg::MODE_POLL: begin
          res_tmo <= current_timeout;
          res_ok  <= 1'b1;
        end
        aps_pkg::MODE_ADD:    res_ok <= slot_ok;
        aps_pkg::MODE_REMOVE: res_ok <= slot_ok && slot_valid[slot_idx];
        default:              res_ok <= 1'b0;
      endcase
    end else if (cmd.commit) begin
      if (res_found) begin
        res_tmo <= 32'(poll_timeout);
      end
    end else if (c_vld && c_sched && !res_found) begin
      if (due) begin
        res_found <= 1'b1;
        res_slot  <= 3'(c_idx);
        f_idx     <= c_idx;
        f_period  <= c_period;
        f_count   <= c_count;
      end else if (diff < res_tmo) begin
        res_tmo <= diff;
      end
    end
  end

  aps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rand_value),
    .divisor  (aps_pkg::interval(32'd0, add_period, prod)),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {res_ok, res_tmo, res_slot, res_found};
    end
  end

  assign stat.mode       = mode;
  assign stat.issue_done = scan_cnt == CNT_W'(NUM_SLOTS);
  assign stat.scan_end   = res_found || eval_done;
  assign stat.div_busy   = div_busy;
  assign stat.out_busy   = out_valid && !out_ready;

endmodule

// File: design/aps_ctrl.sv
// Controller state machine: sequences dispatch, slot scan, commit, add jitter
// and result hand-off. Depends on aps_pkg.
module aps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  aps_pkg::stat_t stat,
  output aps_pkg::cmd_t  cmd
);

  aps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      aps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = aps_pkg::ST_DISPATCH;
        end
      end
      aps_pkg::ST_DISPATCH: begin
        cmd.dispatch = 1'b1;
        unique case (stat.mode)
          aps_pkg::MODE_POLL: state_next = aps_pkg::ST_SCAN;
          aps_pkg::MODE_ADD: begin
            cmd.mul_add = 1'b1;
            state_next  = aps_pkg::ST_ADD_IV;
          end
          default: state_next = aps_pkg::ST_FINISH;
        endcase
      end
      aps_pkg::ST_SCAN: begin
        cmd.issue = !stat.issue_done;
        if (stat.scan_end) begin
          state_next = aps_pkg::ST_COMMIT;
        end
      end
      aps_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = aps_pkg::ST_FINISH;
      end
      aps_pkg::ST_ADD_IV: begin
        cmd.div_start = 1'b1;
        state_next    = aps_pkg::ST_ADD_DIV;
      end
      aps_pkg::ST_ADD_DIV: begin
        if (!stat.div_busy) begin
          cmd.add_write = 1'b1;
          state_next    = aps_pkg::ST_FINISH;
        end
      end
      aps_pkg::ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = aps_pkg::ST_IDLE;
        end
      end
      default: state_next = aps_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/announcement_period_scheduler_core.sv
// Announcement period scheduler: a table of announcer slots with add, remove and poll.
// Items enter on s_axis (tuser = mode: 0 poll, 1 add, 2 remove) and each gives one
// result transaction on m_axis. poll_timeout is written on the cfg channel, which is
// always ready; write it only while the block is idle.
// Steps, from the input transaction to the result in the output register:
//   remove or unknown mode: dispatch, then finish
//   poll: dispatch, then the slot scan pipeline (one slot read from the slot memory
//     per cycle, then multiply, interval add and compare stages), which ends early
//     when a due slot is found, then commit and finish
//   add: dispatch with the multiply, then the bit-serial remainder unit (one bit of
//     the 31-bit jitter value per cycle), then the slot write and finish
// One item is in work at a time. A new item is taken while the previous result still
// waits in the output register; a finished item holds in its last state until the
// output register is free, so a stalled receiver stalls the input after one item.
// Reset clears all slots to empty, sets poll_timeout to 60 and empties the output.
module announcement_period_scheduler_core #(
  parameter int NUM_SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[2:0], now_s[34:3], add_period[66:35], rand_value[97:67],
  // current_timeout[129:98], can_send[130], zero fill [135:131]
  input  logic [135:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // due_found[0], due_slot[3:1], next_poll[35:4], ok[36], zero fill [39:37]
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  aps_pkg::cmd_t  cmd;
  aps_pkg::stat_t stat;
  logic [36:0]    out_data;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {3'b000, out_data};

  aps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aps_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (s_axis_tuser),
    .in_data   (s_axis_tdata[130:0]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data)
  );

endmodule
